// File: hw/rtl/ctpg_pkg.sv
// Shared types, constants and helpers for the conservative-to-primitive gradient block.
`timescale 1ns / 1ps
`default_nettype none
package ctpg_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_LAT       = 33;
    localparam int MUL_LAT       = 2;
    localparam int CFG_W         = 31;

    typedef logic signed [31:0] t_fx;
    typedef logic [1:0]         t_cfg_idx;

    localparam t_cfg_idx CFG_GAMMA_M1 = 2'd0;
    localparam t_cfg_idx CFG_INV_CV   = 2'd1;

    localparam logic [CFG_W-1:0] CFG_RESET = 31'd26214;

    typedef struct packed {
        logic [30:0] density;
        t_fx         mom_x;
        t_fx         mom_y;
        t_fx         mom_z;
        t_fx         energy;
        t_fx         d_density;
        t_fx         d_mom_x;
        t_fx         d_mom_y;
        t_fx         d_mom_z;
        t_fx         d_energy;
        logic        last_state;
    } t_in_item;

    typedef struct packed {
        t_fx  d_pressure;
        t_fx  d_vel_x;
        t_fx  d_vel_y;
        t_fx  d_vel_z;
        t_fx  d_temperature;
        logic bad_density;
        logic last_result;
    } t_out_item;

    // Clamp a widened signed sum into the 32-bit range.
    function automatic t_fx sat34(input logic signed [33:0] x);
        if (x > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -34'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return t_fx'(x[31:0]);
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/conservative_to_primitive_gradient_top.sv
// Top level of the conservative-to-primitive gradient pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Converts one conserved ideal-gas state and its five derivatives along one
// direction into derivatives of pressure, the three velocities and
// temperature, all signed fixed point with FRAC_BITS fraction bits. One
// transaction enters per clock while the pipeline is not held; a result
// passes through two chained banks of 33-stage pipelined dividers
// (velocities, then the velocity and temperature derivatives) and the
// multiplier and adder stages between them. A zero density forces the
// five derivatives to zero and raises bad_density. The output register is
// backed by a one-entry skid buffer, so input transactions keep flowing while
// a result waits; the pipeline holds only once the skid entry is occupied.
// Configuration writes take effect at once and belong in idle periods.
module conservative_to_primitive_gradient_top #(
    parameter int FRAC_BITS = ctpg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ctpg_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ctpg_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire ctpg_pkg::t_cfg_idx   i_cfg_idx,
    input  wire logic [30:0]          i_cfg_data
);
    import ctpg_pkg::*;

    localparam int DL  = DIV_LAT;
    localparam int LAT = 2 * DL + 10;

    // Configuration registers
    logic [CFG_W-1:0] r_gm1, r_icv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm1 <= CFG_RESET;
            r_icv <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAMMA_M1: r_gm1 <= i_cfg_data;
                CFG_INV_CV:   r_icv <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Global advance: the whole pipe moves unless the skid entry is full.
    logic en;
    logic r_skid_v, r_out_v;
    logic take;
    logic [LAT:0] r_v;

    assign en         = !r_skid_v;
    assign o_in_ready = en;
    assign take       = r_out_v & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-1:0], i_in_valid};
        end
    end

    // Input register
    t_in_item r_s0;
    logic     r_bad0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0   <= i_in_data;
            r_bad0 <= (i_in_data.density == '0);
        end
    end

    // Velocities and specific energy
    t_fx u, v, w, e;
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (.i_clk, .i_en(en), .i_num(r_s0.mom_x),
        .i_den(r_s0.density), .o_quo(u));
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (.i_clk, .i_en(en), .i_num(r_s0.mom_y),
        .i_den(r_s0.density), .o_quo(v));
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_w (.i_clk, .i_en(en), .i_num(r_s0.mom_z),
        .i_den(r_s0.density), .o_quo(w));
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_e (.i_clk, .i_en(en), .i_num(r_s0.energy),
        .i_den(r_s0.density), .o_quo(e));

    // Align the raw derivatives with the divider outputs
    t_fx dmx_a, dmy_a, dmz_a, drho_a, dmx_b, dmy_b, dmz_b, drho_b, den_a;
    ctpg_dly #(.WIDTH(32), .DEPTH(DL)) u_dl_dmx (.i_clk, .i_en(en), .i_d(r_s0.d_mom_x),
        .o_q(dmx_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(DL)) u_dl_dmy (.i_clk, .i_en(en), .i_d(r_s0.d_mom_y),
        .o_q(dmy_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(DL)) u_dl_dmz (.i_clk, .i_en(en), .i_d(r_s0.d_mom_z),
        .o_q(dmz_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(DL)) u_dl_drho (.i_clk, .i_en(en), .i_d(r_s0.d_density),
        .o_q(drho_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dl_dmx2 (.i_clk, .i_en(en), .i_d(dmx_a),
        .o_q(dmx_b));
    ctpg_dly #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dl_dmy2 (.i_clk, .i_en(en), .i_d(dmy_a),
        .o_q(dmy_b));
    ctpg_dly #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dl_dmz2 (.i_clk, .i_en(en), .i_d(dmz_a),
        .o_q(dmz_b));
    ctpg_dly #(.WIDTH(32), .DEPTH(4)) u_dl_drho2 (.i_clk, .i_en(en), .i_d(drho_a),
        .o_q(drho_b));
    ctpg_dly #(.WIDTH(32), .DEPTH(DL + 6)) u_dl_den (.i_clk, .i_en(en), .i_d(r_s0.d_energy),
        .o_q(den_a));

    // Products of the velocities
    t_fx uu, vv, ww, udx, vdy, wdz, udr, vdr, wdr;
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_uu (.i_clk, .i_en(en), .i_a(u), .i_b(u), .o_p(uu));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vv (.i_clk, .i_en(en), .i_a(v), .i_b(v), .o_p(vv));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ww (.i_clk, .i_en(en), .i_a(w), .i_b(w), .o_p(ww));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_udx (.i_clk, .i_en(en), .i_a(u), .i_b(dmx_a),
        .o_p(udx));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vdy (.i_clk, .i_en(en), .i_a(v), .i_b(dmy_a),
        .o_p(vdy));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_wdz (.i_clk, .i_en(en), .i_a(w), .i_b(dmz_a),
        .o_p(wdz));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_udr (.i_clk, .i_en(en), .i_a(u), .i_b(drho_a),
        .o_p(udr));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vdr (.i_clk, .i_en(en), .i_a(v), .i_b(drho_a),
        .o_p(vdr));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_wdr (.i_clk, .i_en(en), .i_a(w), .i_b(drho_a),
        .o_p(wdr));

    // Sum stage: kinetic term, dot product, velocity numerators
    t_fx r_k, r_dot, r_nx, r_ny, r_nz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k   <= sat34(34'(uu) + 34'(vv) + 34'(ww));
            r_dot <= sat34(34'(udx) + 34'(vdy) + 34'(wdz));
            r_nx  <= sat34(34'(dmx_b) - 34'(udr));
            r_ny  <= sat34(34'(dmy_b) - 34'(vdr));
            r_nz  <= sat34(34'(dmz_b) - 34'(wdr));
        end
    end

    // Density delayed to the second divider bank
    logic [30:0] rho_a, rho_b;
    ctpg_dly #(.WIDTH(31), .DEPTH(DL + 3)) u_dl_rho (.i_clk, .i_en(en),
        .i_d(r_s0.density), .o_q(rho_a));
    ctpg_dly #(.WIDTH(31), .DEPTH(6)) u_dl_rho2 (.i_clk, .i_en(en), .i_d(rho_a), .o_q(rho_b));

    t_fx dvx, dvy, dvz;
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_dvx (.i_clk, .i_en(en), .i_num(r_nx),
        .i_den(rho_a), .o_quo(dvx));
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_dvy (.i_clk, .i_en(en), .i_num(r_ny),
        .i_den(rho_a), .o_quo(dvy));
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_dvz (.i_clk, .i_en(en), .i_num(r_nz),
        .i_den(rho_a), .o_quo(dvz));

    // Half kinetic and kinetic minus energy
    t_fx e_a, r_hk, r_ke, dot_a;
    ctpg_dly #(.WIDTH(32), .DEPTH(3)) u_dl_e (.i_clk, .i_en(en), .i_d(e), .o_q(e_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(3)) u_dl_dot (.i_clk, .i_en(en), .i_d(r_dot), .o_q(dot_a));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hk <= t_fx'({1'b0, r_k[31:1]});
            r_ke <= sat34(34'(r_k) - 34'(e_a));
        end
    end

    t_fx hkdr, kedr;
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_hk (.i_clk, .i_en(en), .i_a(r_hk), .i_b(drho_b),
        .o_p(hkdr));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ke (.i_clk, .i_en(en), .i_a(r_ke), .i_b(drho_b),
        .o_p(kedr));

    t_fx r_pin, r_tin;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pin <= sat34(34'(hkdr) - 34'(dot_a) + 34'(den_a));
            r_tin <= sat34(34'(kedr) - 34'(dot_a) + 34'(den_a));
        end
    end

    // Scale by the gas constants
    t_fx dp, ct, dt;
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_dp (.i_clk, .i_en(en), .i_a(t_fx'({1'b0, r_gm1})),
        .i_b(r_pin), .o_p(dp));
    ctpg_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ct (.i_clk, .i_en(en), .i_a(t_fx'({1'b0, r_icv})),
        .i_b(r_tin), .o_p(ct));
    ctpg_div #(.FRAC_BITS(FRAC_BITS)) u_div_dt (.i_clk, .i_en(en), .i_num(ct),
        .i_den(rho_b), .o_quo(dt));

    // Align everything with the temperature divider
    t_fx dp_a, dvx_a, dvy_a, dvz_a;
    logic [1:0] flags_a;
    ctpg_dly #(.WIDTH(32), .DEPTH(DL)) u_dl_dp (.i_clk, .i_en(en), .i_d(dp), .o_q(dp_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(6)) u_dl_dvx (.i_clk, .i_en(en), .i_d(dvx), .o_q(dvx_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(6)) u_dl_dvy (.i_clk, .i_en(en), .i_d(dvy), .o_q(dvy_a));
    ctpg_dly #(.WIDTH(32), .DEPTH(6)) u_dl_dvz (.i_clk, .i_en(en), .i_d(dvz), .o_q(dvz_a));
    ctpg_dly #(.WIDTH(2), .DEPTH(LAT - 1)) u_dl_flg (.i_clk, .i_en(en),
        .i_d({r_bad0, r_s0.last_state}), .o_q(flags_a));

    // Tail register: force zeros on a bad density
    t_out_item r_fin;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin.bad_density <= flags_a[1];
            r_fin.last_result <= flags_a[0];
            if (flags_a[1]) begin
                r_fin.d_pressure    <= '0;
                r_fin.d_vel_x       <= '0;
                r_fin.d_vel_y       <= '0;
                r_fin.d_vel_z       <= '0;
                r_fin.d_temperature <= '0;
            end else begin
                r_fin.d_pressure    <= dp_a;
                r_fin.d_vel_x       <= dvx_a;
                r_fin.d_vel_y       <= dvy_a;
                r_fin.d_vel_z       <= dvz_a;
                r_fin.d_temperature <= dt;
            end
        end
    end

    // Output register with one-entry skid
    t_out_item r_out, r_skid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_v[LAT]) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (r_v[LAT]) begin
            if (!r_out_v || take) begin
                r_out <= r_fin;
            end else begin
                r_skid <= r_fin;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid entry held without output entry");
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !take) |=> r_skid_v) else $error("skid entry dropped");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.bad_density) |-> (r_out.d_pressure == '0 && r_out.d_vel_x == '0
        && r_out.d_vel_y == '0 && r_out.d_vel_z == '0 && r_out.d_temperature == '0))
        else $error("bad density result not zeroed");
    a_out_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_skid_v) |=> r_out_v) else $error("skid entry not moved to output");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/ctpg_dly.sv
// Enabled shift-register delay line.
`timescale 1ns / 1ps
`default_nettype none
module ctpg_dly #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int j = 1; j < DEPTH; j++) begin
                r_tap[j] <= r_tap[j-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule
`default_nettype wire

// File: hw/rtl/ctpg_mul.sv
// Two-stage saturating fixed-point multiplier, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module ctpg_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire ctpg_pkg::t_fx     i_a,
    input  wire ctpg_pkg::t_fx     i_b,
    output ctpg_pkg::t_fx          o_p
);
    import ctpg_pkg::*;

    logic [31:0] ma, mb;
    logic [63:0] r_prod;
    logic        r_neg;
    logic [63:0] m;
    t_fx         n_p;
    t_fx         r_p;

    assign ma = i_a[31] ? 32'(-i_a) : 32'(i_a);
    assign mb = i_b[31] ? 32'(-i_b) : 32'(i_b);

    always_comb begin
        m = r_prod >> FRAC_BITS;
        if (r_neg) begin
            n_p = (m > 64'h80000000) ? 32'sh80000000 : t_fx'(32'(-m));
        end else begin
            n_p = (m > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : t_fx'(m[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(ma) * 64'(mb);
            r_neg  <= i_a[31] ^ i_b[31];
            r_p    <= n_p;
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// File: hw/rtl/ctpg_div.sv
// Pipelined restoring divider: (n << FRAC_BITS) / d, one quotient bit per stage, saturated.
`timescale 1ns / 1ps
`default_nettype none
module ctpg_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire ctpg_pkg::t_fx     i_num,
    input  wire logic [30:0]       i_den,
    output ctpg_pkg::t_fx          o_quo
);
    import ctpg_pkg::*;

    localparam int SH = 31 - FRAC_BITS;

    logic [31:0] mag_in;
    logic [62:0] den_sh;
    logic        sat_in;

    logic [31:0] r_mag [32];
    logic [30:0] r_den [32];
    logic [30:0] r_rem [32];
    logic [30:0] r_q   [32];
    logic        r_neg [32];
    logic        r_sat [32];
    t_fx         r_quo;
    t_fx         n_quo;

    assign mag_in = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign den_sh = 63'(i_den) << SH;
    assign sat_in = (63'(mag_in) >= den_sh);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0] <= mag_in;
            r_den[0] <= i_den;
            r_rem[0] <= 31'(mag_in >> SH);
            r_q[0]   <= '0;
            r_neg[0] <= i_num[31];
            r_sat[0] <= sat_in;
        end
    end

    for (genvar j = 1; j < 32; j++) begin : g_stage
        localparam int BI = 31 - j;
        logic        nbit;
        logic [31:0] trial;
        logic        ge;

        if (BI >= FRAC_BITS) begin : g_bit
            assign nbit = r_mag[j-1][BI-FRAC_BITS];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {r_rem[j-1], nbit};
        assign ge    = (trial >= {1'b0, r_den[j-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[j] <= r_mag[j-1];
                r_den[j] <= r_den[j-1];
                r_rem[j] <= ge ? 31'(trial - {1'b0, r_den[j-1]}) : trial[30:0];
                r_q[j]   <= r_q[j-1] | (ge ? (31'd1 << BI) : 31'd0);
                r_neg[j] <= r_neg[j-1];
                r_sat[j] <= r_sat[j-1];
            end
        end
    end

    always_comb begin
        if (r_sat[31]) begin
            n_quo = r_neg[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (r_neg[31]) begin
            n_quo = t_fx'(-{1'b0, r_q[31]});
        end else begin
            n_quo = t_fx'({1'b0, r_q[31]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;
endmodule
`default_nettype wire

// File: sim/conservative_to_primitive_gradient_top_test.sv
// Testbench for the conservative-to-primitive gradient pipeline.
`timescale 1ns / 1ps
module conservative_to_primitive_gradient_top_test;
    import ctpg_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 77;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // Saturate a wide signed value into the 32-bit range.
    function automatic longint clamp32(input longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic longint absval(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Fixed-point product, truncated toward zero, saturated.
    function automatic longint fx_prod(input longint a, input longint b);
        longint m;
        m = (absval(a) * absval(b)) >>> FB;
        return clamp32(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    // Fixed-point quotient by a positive density, truncated toward zero.
    function automatic longint fx_quot(input longint n, input longint d);
        longint q;
        q = (absval(n) << FB) / d;
        return clamp32((n < 0) ? -q : q);
    endfunction

    // Scoreboard of expected gradient results.
    class gradient_board;
        t_out_item pending[$];
        longint gm1 = 26214;
        longint icv = 26214;
        int mismatches = 0;

        function void note_input(t_in_item it);
            t_out_item r;
            longint rho, u, v, w, e, k, dot, pin, tin;
            rho = it.density;
            r = '0;
            r.last_result = it.last_state;
            if (rho == 0) begin
                r.bad_density = 1'b1;
            end else begin
                u = fx_quot(it.mom_x, rho);
                v = fx_quot(it.mom_y, rho);
                w = fx_quot(it.mom_z, rho);
                e = fx_quot(it.energy, rho);
                k = clamp32(fx_prod(u, u) + fx_prod(v, v) + fx_prod(w, w));
                dot = clamp32(fx_prod(u, it.d_mom_x) + fx_prod(v, it.d_mom_y)
                              + fx_prod(w, it.d_mom_z));
                pin = clamp32(fx_prod(k >>> 1, it.d_density) - dot + it.d_energy);
                r.d_pressure = fx_prod(gm1, pin);
                r.d_vel_x = fx_quot(clamp32(it.d_mom_x - fx_prod(u, it.d_density)), rho);
                r.d_vel_y = fx_quot(clamp32(it.d_mom_y - fx_prod(v, it.d_density)), rho);
                r.d_vel_z = fx_quot(clamp32(it.d_mom_z - fx_prod(w, it.d_density)), rho);
                tin = clamp32(fx_prod(clamp32(k - e), it.d_density) - dot + it.d_energy);
                r.d_temperature = fx_quot(fx_prod(icv, tin), rho);
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_data;
    logic cfg_we = 1'b0;
    t_cfg_idx cfg_idx = CFG_GAMMA_M1;
    logic [30:0] cfg_data = '0;
    longint cycles = 0;
    int stall_mode = 0;
    gradient_board board = new();

    conservative_to_primitive_gradient_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Score both handshakes at the rising edge; abort on the cycle limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && in_ready) board.note_input(in_data);
        if (rst_n && out_valid && out_ready) board.check_result(out_data);
        if (cycles > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stall pattern: phases of always-ready, random, and heavy stalls.
    always @(negedge clk) begin
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    // Write one register while the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [30:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_GAMMA_M1) board.gm1 = val;
        else if (idx == CFG_INV_CV) board.icv = val;
    endtask

    // Present one transaction and hold it until accepted.
    task automatic send_item(input t_in_item it);
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid for a random gap between bursts.
    task automatic idle_gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Wait for every expected result, then let the pipeline drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_fx(input int shape);
        case (shape)
            0: return $urandom();
            1: return $signed($urandom_range(0, 16'hFFFF)) - 32'sd32768;
            2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    function automatic t_in_item rnd_item();
        t_in_item it;
        int sh;
        sh = $urandom_range(0, 9);
        it.density = (sh == 0) ? 31'd0 : (sh < 3) ? 31'($urandom())
                   : (sh == 3) ? 31'h7FFFFFFF : 31'($urandom_range(1, 32'h40000));
        it.mom_x = rnd_fx($urandom_range(0, 3));
        it.mom_y = rnd_fx($urandom_range(0, 3));
        it.mom_z = rnd_fx($urandom_range(0, 3));
        it.energy = rnd_fx($urandom_range(0, 3));
        it.d_density = rnd_fx($urandom_range(0, 3));
        it.d_mom_x = rnd_fx($urandom_range(0, 3));
        it.d_mom_y = rnd_fx($urandom_range(0, 3));
        it.d_mom_z = rnd_fx($urandom_range(0, 3));
        it.d_energy = rnd_fx($urandom_range(0, 3));
        it.last_state = $urandom_range(0, 1);
        return it;
    endfunction

    // Random phase: bursts of transactions separated by random gaps.
    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_item(rnd_item());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
    endtask

    initial begin
        t_in_item it;
        logic [30:0] gvals [4];
        logic [30:0] cvals [4];
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes, zero density, unit density, saturation.
        it = '0;
        send_item(it);
        it.density = 31'h10000;
        it.mom_x = 32'h10000; it.mom_y = 32'hFFFF0000; it.mom_z = 32'h8000;
        it.energy = 32'h30000; it.d_density = 32'h10000; it.d_mom_x = 32'h20000;
        it.d_mom_y = 32'h1000; it.d_mom_z = 32'hFFFFF000; it.d_energy = 32'h50000;
        it.last_state = 1'b1;
        send_item(it);
        it.density = 31'd1;
        send_item(it);
        it.density = 31'h7FFFFFFF;
        send_item(it);
        it = '1;
        send_item(it);
        it.density = 31'd0;
        send_item(it);
        it = '0;
        it.density = 31'd1;
        it.mom_x = 32'h80000000; it.mom_y = 32'h7FFFFFFF; it.mom_z = 32'h80000000;
        it.energy = 32'h7FFFFFFF; it.d_density = 32'h80000000;
        it.d_mom_x = 32'h7FFFFFFF; it.d_mom_y = 32'h80000000;
        it.d_mom_z = 32'h7FFFFFFF; it.d_energy = 32'h80000000;
        send_item(it);
        it.density = 31'h100;
        it.d_density = 32'h7FFFFFFF; it.d_energy = 32'h7FFFFFFF;
        send_item(it);
        repeat (12) send_item(rnd_item());
        drain();

        gvals = '{31'd0, 31'h7FFFFFFF, 31'h6666, 31'h1_0000};
        cvals = '{31'h7FFFFFFF, 31'd0, 31'h2000, 31'h1_8000};
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_GAMMA_M1, gvals[p]);
            write_reg(CFG_INV_CV, cvals[p]);
            random_phase(275);
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/ctpg_pkg.sv
hw/rtl/ctpg_dly.sv
hw/rtl/ctpg_mul.sv
hw/rtl/ctpg_div.sv
hw/rtl/conservative_to_primitive_gradient_top.sv
sim/conservative_to_primitive_gradient_top_test.sv
